FILE: rtl/spag_pkg.sv
// Shared types, constants and the quarter-wave table generator for the sine NCO.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package spag_pkg;

  localparam int PHASE_BITS_DEF = 32;
  localparam int TABLE_BITS_DEF = 10;

  localparam int STEP_W     = 32;
  localparam int AMP_W      = 15;
  localparam int MAG_W      = 15;
  localparam int SAMPLE_W   = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 2 * SAMPLE_W;

  localparam logic [STEP_W-1:0] STEP_RESET = 32'd89478485;
  localparam logic [AMP_W-1:0]  AMP_RESET  = 15'd20000;
  localparam logic [MAG_W-1:0]  FULL_SCALE = 15'd32767;
  localparam logic [63:0]       HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0]       ROUND_Q30   = 64'd536870912;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PHASE_STEP = 2'd0,
    REG_AMPLITUDE  = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    logic full;
    logic neg;
  } lk_flags_t;

  // Q2.30 Taylor series for sin over the first quadrant, scaled to unsigned Q0.15
  function automatic logic [MAG_W-1:0] quarter_entry(input int unsigned k,
                                                     input int unsigned tb);
    logic [63:0] a;
    logic [63:0] a2;
    logic [63:0] t;
    logic [63:0] sum;
    logic [63:0] v;
    a   = (64'(k) * HALF_PI_Q30) >> tb;
    a2  = (a * a) >> 30;
    t   = a;
    sum = a;
    t   = ((t * a2) >> 30) / 64'd6;
    sum = sum - t;
    t   = ((t * a2) >> 30) / 64'd20;
    sum = sum + t;
    t   = ((t * a2) >> 30) / 64'd42;
    sum = sum - t;
    t   = ((t * a2) >> 30) / 64'd72;
    sum = sum + t;
    t   = ((t * a2) >> 30) / 64'd110;
    sum = sum - t;
    t   = ((t * a2) >> 30) / 64'd156;
    sum = sum + t;
    v   = (sum * 64'(FULL_SCALE) + ROUND_Q30) >> 30;
    if (v > 64'(FULL_SCALE)) begin
      v = 64'(FULL_SCALE);
    end
    return v[MAG_W-1:0];
  endfunction

endpackage

FILE: rtl/sine_phase_accumulator_generator.sv
// Top level of the sine NCO: configuration registers, stream ports, submodule wiring.
// Depends on spag_pkg, spag_phase, spag_rom and spag_scale.
`timescale 1ns / 1ps

// Direct digital synthesis sine source. Each input word whose bit 0 is set
// yields one output word with amplitude * sin(phase) on both channels, then
// the phase advances by phase_step (a fraction of a turn times 2^32). A word
// with bit 0 clear is taken and produces nothing. One word is accepted per
// clock unless output back-pressure holds the pipeline; a result passes the
// table read, the multiply and the output register, since the table memory
// and the multiplier are registered. The output register and per-stage
// handshake let requests enter while a result is still waiting. The user must
// write registers through the cfg port (index 0 phase_step, 1 amplitude) only
// while idle, and the block does not enforce it; no clearing pass after reset.
module sine_phase_accumulator_generator #(
  parameter int PHASE_BITS = spag_pkg::PHASE_BITS_DEF,
  parameter int TABLE_BITS = spag_pkg::TABLE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [spag_pkg::IN_DATA_W-1:0]    in_tdata,   // [0] sample_request
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [spag_pkg::OUT_DATA_W-1:0]   out_tdata,  // [15:0] left, [31:16] right
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [spag_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [spag_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import spag_pkg::*;

  logic [STEP_W-1:0]      phase_step_r;
  logic [AMP_W-1:0]       amplitude_r;
  logic                   req;
  logic [TABLE_BITS-1:0]  rom_addr;
  lk_flags_t              flags;
  logic [MAG_W-1:0]       rom_data;
  logic [SAMPLE_W-1:0]    sample;

  assign cfg_ready = 1'b1;
  assign req       = in_tvalid && in_tready && in_tdata[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_step_r <= STEP_RESET;
      amplitude_r  <= AMP_RESET;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_PHASE_STEP: phase_step_r <= cfg_data[STEP_W-1:0];
        REG_AMPLITUDE:  amplitude_r  <= cfg_data[AMP_W-1:0];
        default: ;
      endcase
    end
  end

  spag_phase #(
    .PHASE_BITS (PHASE_BITS),
    .TABLE_BITS (TABLE_BITS)
  ) u_phase (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_en    (req),
    .phase_step (phase_step_r),
    .rom_addr   (rom_addr),
    .flags      (flags)
  );

  spag_rom #(
    .TABLE_BITS (TABLE_BITS)
  ) u_rom (
    .clk     (clk),
    .rd_en   (in_tready),
    .rd_addr (rom_addr),
    .rd_data (rom_data)
  );

  spag_scale u_scale (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (req),
    .in_ready   (in_tready),
    .in_flags   (flags),
    .rom_data   (rom_data),
    .amplitude  (amplitude_r),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_sample (sample)
  );

  assign out_tdata = {sample, sample};

endmodule

FILE: rtl/spag_rom.sv
// Quarter-wave sine table with a registered synchronous read.
// Depends on spag_pkg for the entry generator.
`timescale 1ns / 1ps

module spag_rom #(
  parameter int TABLE_BITS = spag_pkg::TABLE_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rd_en,
  input  logic [TABLE_BITS-1:0]       rd_addr,
  output logic [spag_pkg::MAG_W-1:0]  rd_data
);
  import spag_pkg::*;

  localparam int QLEN = 1 << TABLE_BITS;

  logic [MAG_W-1:0] rom_w [QLEN];
  logic [MAG_W-1:0] rd_data_r;

  generate
    for (genvar k = 0; k < QLEN; k++) begin : g_rom
      assign rom_w[k] = quarter_entry(k, TABLE_BITS);
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= rom_w[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: rtl/spag_phase.sv
// Phase accumulator and quarter-wave address folding.
// Depends on spag_pkg for widths and the lookup flag struct.
`timescale 1ns / 1ps

module spag_phase #(
  parameter int PHASE_BITS = spag_pkg::PHASE_BITS_DEF,
  parameter int TABLE_BITS = spag_pkg::TABLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          step_en,
  input  logic [spag_pkg::STEP_W-1:0]   phase_step,
  output logic [TABLE_BITS-1:0]         rom_addr,
  output spag_pkg::lk_flags_t           flags
);
  import spag_pkg::*;

  logic [PHASE_BITS-1:0]   phase_r;
  logic [PHASE_BITS-1:0]   phase_nxt;
  logic [PHASE_BITS-1:0]   step_al;
  logic [TABLE_BITS+1:0]   top;
  logic [1:0]              quad;
  logic [TABLE_BITS-1:0]   idx;

  generate
    if (PHASE_BITS >= STEP_W) begin : g_wide
      assign step_al = PHASE_BITS'(phase_step) << (PHASE_BITS - STEP_W);
    end else begin : g_narrow
      assign step_al = phase_step[STEP_W-1 -: PHASE_BITS];
    end
  endgenerate

  assign top  = phase_r[PHASE_BITS-1 -: TABLE_BITS+2];
  assign quad = top[TABLE_BITS+1:TABLE_BITS];
  assign idx  = top[TABLE_BITS-1:0];

  // odd quadrants run the table backwards; index zero there is the peak
  assign rom_addr   = quad[0] ? (~idx + 1'b1) : idx;
  assign flags.full = quad[0] && (idx == '0);
  assign flags.neg  = quad[1];

  always_comb begin
    phase_nxt = phase_r;
    if (step_en) begin
      phase_nxt = phase_r + step_al;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
    end else begin
      phase_r <= phase_nxt;
    end
  end

endmodule

FILE: rtl/spag_scale.sv
// Sample pipeline: table-read stage, amplitude multiply, sign and output register.
// Depends on spag_pkg; reads table data from spag_rom.
`timescale 1ns / 1ps

module spag_scale (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  spag_pkg::lk_flags_t            in_flags,
  input  logic [spag_pkg::MAG_W-1:0]     rom_data,
  input  logic [spag_pkg::AMP_W-1:0]     amplitude,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [spag_pkg::SAMPLE_W-1:0]  out_sample
);
  import spag_pkg::*;

  logic                     s1_v_r;
  lk_flags_t                s1_flags_r;
  logic                     s2_v_r;
  logic                     s2_neg_r;
  logic [MAG_W+AMP_W-1:0]   prod_r;
  logic                     out_v_r;
  logic [SAMPLE_W-1:0]      out_sample_r;

  logic                     out_adv;
  logic                     s2_adv;
  logic                     s1_adv;
  logic [MAG_W-1:0]         mag;
  logic [SAMPLE_W-1:0]      mag_ext;

  assign out_adv  = !out_v_r || out_ready;
  assign s2_adv   = !s2_v_r || out_adv;
  assign s1_adv   = !s1_v_r || s2_adv;
  assign in_ready = s1_adv;

  assign mag     = s1_flags_r.full ? FULL_SCALE : rom_data;
  assign mag_ext = {1'b0, prod_r[MAG_W+AMP_W-1 -: MAG_W]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (s1_adv) begin
        s1_v_r <= in_valid;
      end
      if (s2_adv) begin
        s2_v_r <= s1_v_r;
      end
      if (out_adv) begin
        out_v_r <= s2_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s1_flags_r <= in_flags;
    end
    if (s2_adv) begin
      prod_r   <= (MAG_W+AMP_W)'(mag) * (MAG_W+AMP_W)'(amplitude);
      s2_neg_r <= s1_flags_r.neg;
    end
    if (out_adv && s2_v_r) begin
      out_sample_r <= s2_neg_r ? (~mag_ext + 1'b1) : mag_ext;
    end
  end

  assign out_valid  = out_v_r;
  assign out_sample = out_sample_r;

  // table read is enabled from in_ready, so a held stage must see held data
  a_rom_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |=> $stable(rom_data))
    else $error("table data changed while read stage held");

  a_no_min: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> out_sample_r != {1'b1, {(SAMPLE_W-1){1'b0}}})
    else $error("sample magnitude beyond full scale");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    s2_v_r && !out_v_r |=> out_v_r)
    else $error("product stage failed to reach output register");

endmodule
